// ===== rtl/core/recent_id_list_move_to_front_macros.svh =====
// assertion helpers for the top-level rtl file
`ifndef RECENT_ID_LIST_MOVE_TO_FRONT_MACROS_SVH
`define RECENT_ID_LIST_MOVE_TO_FRONT_MACROS_SVH

// condition holds at every clock edge outside reset
`define RMTF_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("rmtf assertion failed");

// consequent holds in the cycle after the antecedent
`define RMTF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmtf assertion failed");

`endif

// ===== rtl/core/rmtf_pkg.sv =====
`timescale 1ns / 1ps
package rmtf_pkg;

  localparam int LIST_DEPTH = 8;
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  localparam int ID_W       = 8;
  localparam int POS_W      = 8;
  localparam int REQ_W      = 2;
  localparam int IDX_OUT_W  = 3;
  localparam int CNT_OUT_W  = 4;
  localparam int MASK_W     = 64;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MASK_0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NULL_ID = 3'd4;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD  = 2'd0,
    REQ_DEL  = 2'd1,
    REQ_GET  = 2'd2,
    REQ_FIND = 2'd3
  } req_t;

  typedef struct packed {
    logic load_left;
    logic load_right;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/rmtf_cell.sv =====
`timescale 1ns / 1ps
module rmtf_cell (
  input  logic                        clk,
  input  rmtf_pkg::cell_ctrl_t        ctrl,
  input  logic [rmtf_pkg::ID_W-1:0]   left_data,
  input  logic [rmtf_pkg::ID_W-1:0]   right_data,
  input  logic [rmtf_pkg::ID_W-1:0]   key,
  output logic [rmtf_pkg::ID_W-1:0]   data,
  output logic                        key_eq
);

  logic [rmtf_pkg::ID_W-1:0] entry_r;
  logic [rmtf_pkg::ID_W-1:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.load_left) begin
      entry_nxt = left_data;
    end else if (ctrl.load_right) begin
      entry_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign data   = entry_r;
  assign key_eq = (entry_r == key);

endmodule

// ===== rtl/core/rmtf_ctrl.sv =====
`timescale 1ns / 1ps
module rmtf_ctrl (
  input  logic                                 active,
  input  rmtf_pkg::req_t                       req_type,
  input  logic [rmtf_pkg::POS_W-1:0]           position,
  input  logic [rmtf_pkg::CNT_W-1:0]           fill,
  input  logic [rmtf_pkg::LIST_DEPTH-1:0]      hit_vec,
  input  logic                                 add_ok,
  output rmtf_pkg::cell_ctrl_t [rmtf_pkg::LIST_DEPTH-1:0] cell_ctrl,
  output logic [rmtf_pkg::CNT_W-1:0]           fill_nxt,
  output logic [rmtf_pkg::IDX_W-1:0]           find_idx,
  output logic                                 find_hit,
  output logic                                 pos_ok
);

  logic insert;

  // lowest matching index wins
  always_comb begin
    find_idx = '0;
    for (int i = rmtf_pkg::LIST_DEPTH - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        find_idx = rmtf_pkg::IDX_W'(i);
      end
    end
  end

  assign find_hit = |hit_vec;
  assign pos_ok   = (position < rmtf_pkg::POS_W'(fill));
  assign insert   = !find_hit && add_ok;

  always_comb begin
    fill_nxt = fill;
    for (int i = 0; i < rmtf_pkg::LIST_DEPTH; i++) begin
      cell_ctrl[i] = '0;
    end
    if (active) begin
      case (req_type)
        rmtf_pkg::REQ_ADD: begin
          for (int i = 0; i < rmtf_pkg::LIST_DEPTH; i++) begin
            // move to front shifts only the cells up to the match; a new id shifts every cell
            if (insert || (find_hit && rmtf_pkg::IDX_W'(i) <= find_idx)) begin
              cell_ctrl[i].load_left = 1'b1;
            end
          end
          if (insert && fill != rmtf_pkg::CNT_W'(rmtf_pkg::LIST_DEPTH)) begin
            fill_nxt = fill + 1'b1;
          end
        end
        rmtf_pkg::REQ_DEL: begin
          if (pos_ok) begin
            for (int i = 0; i < rmtf_pkg::LIST_DEPTH; i++) begin
              if (rmtf_pkg::POS_W'(i) >= position) begin
                cell_ctrl[i].load_right = 1'b1;
              end
            end
            fill_nxt = fill - 1'b1;
          end
        end
        default: begin
          fill_nxt = fill;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/recent_id_list_move_to_front.sv =====
`timescale 1ns / 1ps
// most-recent-first list of 8-bit ids with move to front on repeat add
// input: a transaction is taken at a rising edge with start high and busy low;
//   in_req_type selects add, delete at index, get at index or find id
// config: cfg_we writes cfg_wdata into register cfg_index (allowed masks 0..3,
//   then null id); write only while no transaction is in flight
// output: out_valid is high for exactly one cycle, the cycle after the
//   transaction is taken; out_id_out, out_index_out, out_hit and
//   out_entry_count are valid in that cycle only
// throughput: one transaction per cycle, busy stays low
// the list is a chain of cells, one per entry; every cell compares its entry
//   against the key and loads from its left or right neighbor in the same
//   cycle; the head cell takes the new id as its left data
// reset: entry count, masks and null id go to zero; no result is pending
// the receiver cannot stall: each result must be taken in its strobe cycle
`include "recent_id_list_move_to_front_macros.svh"
module recent_id_list_move_to_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [rmtf_pkg::REQ_W-1:0]           in_req_type,
  input  logic [rmtf_pkg::ID_W-1:0]            in_task_id,
  input  logic [rmtf_pkg::POS_W-1:0]           in_position,
  output logic                                 out_valid,
  output logic [rmtf_pkg::ID_W-1:0]            out_id_out,
  output logic [rmtf_pkg::IDX_OUT_W-1:0]       out_index_out,
  output logic                                 out_hit,
  output logic [rmtf_pkg::CNT_OUT_W-1:0]       out_entry_count,
  input  logic                                 cfg_we,
  input  logic [rmtf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rmtf_pkg::MASK_W-1:0]          cfg_wdata
);

  localparam int D = rmtf_pkg::LIST_DEPTH;

  logic [rmtf_pkg::MASK_W-1:0]    mask_r [4];
  logic [rmtf_pkg::ID_W-1:0]      null_id_r;
  logic [rmtf_pkg::CNT_W-1:0]     fill_r;
  logic [rmtf_pkg::CNT_W-1:0]     fill_nxt;

  logic                           out_valid_r;
  logic [rmtf_pkg::ID_W-1:0]      out_id_r, out_id_nxt;
  logic [rmtf_pkg::IDX_OUT_W-1:0] out_index_r, out_index_nxt;
  logic                           out_hit_r, out_hit_nxt;
  logic [rmtf_pkg::CNT_OUT_W-1:0] out_count_r;

  logic                           accept;
  rmtf_pkg::req_t                 req;
  logic [4*rmtf_pkg::MASK_W-1:0]  allowed;
  logic                           add_ok;
  logic [rmtf_pkg::ID_W-1:0]      entry [D];
  logic [D-1:0]                   key_eq;
  logic [D-1:0]                   hit_vec;
  rmtf_pkg::cell_ctrl_t [D-1:0]   cell_ctrl;
  logic [rmtf_pkg::IDX_W-1:0]     find_idx;
  logic                           find_hit;
  logic                           pos_ok;
  logic [rmtf_pkg::ID_W-1:0]      get_data;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign req    = rmtf_pkg::req_t'(in_req_type);

  assign allowed = {mask_r[3], mask_r[2], mask_r[1], mask_r[0]};
  assign add_ok  = allowed[in_task_id] && (in_task_id != null_id_r);

  genvar g;
  generate
    for (g = 0; g < D; g++) begin : g_cell
      logic [rmtf_pkg::ID_W-1:0] left_data;
      logic [rmtf_pkg::ID_W-1:0] right_data;
      if (g == 0) begin : g_head
        assign left_data = in_task_id;
      end else begin : g_mid
        assign left_data = entry[g-1];
      end
      // the tail takes its own value on delete; that slot falls out of range
      if (g == D - 1) begin : g_tail
        assign right_data = entry[g];
      end else begin : g_body
        assign right_data = entry[g+1];
      end
      rmtf_cell u_cell (
        .clk        (clk),
        .ctrl       (cell_ctrl[g]),
        .left_data  (left_data),
        .right_data (right_data),
        .key        (in_task_id),
        .data       (entry[g]),
        .key_eq     (key_eq[g])
      );
      assign hit_vec[g] = key_eq[g] && (rmtf_pkg::CNT_W'(g) < fill_r);
    end
  endgenerate

  rmtf_ctrl u_ctrl (
    .active    (accept),
    .req_type  (req),
    .position  (in_position),
    .fill      (fill_r),
    .hit_vec   (hit_vec),
    .add_ok    (add_ok),
    .cell_ctrl (cell_ctrl),
    .fill_nxt  (fill_nxt),
    .find_idx  (find_idx),
    .find_hit  (find_hit),
    .pos_ok    (pos_ok)
  );

  always_comb begin
    get_data = '0;
    for (int i = 0; i < D; i++) begin
      if (in_position == rmtf_pkg::POS_W'(i)) begin
        get_data = get_data | entry[i];
      end
    end
  end

  always_comb begin
    out_id_nxt    = '0;
    out_index_nxt = '0;
    out_hit_nxt   = 1'b0;
    case (req)
      rmtf_pkg::REQ_GET: begin
        out_id_nxt  = pos_ok ? get_data : null_id_r;
        out_hit_nxt = pos_ok;
      end
      rmtf_pkg::REQ_FIND: begin
        out_index_nxt = find_hit ? rmtf_pkg::IDX_OUT_W'(find_idx) : '0;
        out_hit_nxt   = find_hit;
      end
      default: begin
        out_hit_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r[0] <= '0;
      mask_r[1] <= '0;
      mask_r[2] <= '0;
      mask_r[3] <= '0;
      null_id_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rmtf_pkg::CFG_MASK_0:  mask_r[0] <= cfg_wdata;
        rmtf_pkg::CFG_MASK_1:  mask_r[1] <= cfg_wdata;
        rmtf_pkg::CFG_MASK_2:  mask_r[2] <= cfg_wdata;
        rmtf_pkg::CFG_MASK_3:  mask_r[3] <= cfg_wdata;
        rmtf_pkg::CFG_NULL_ID: null_id_r <= cfg_wdata[rmtf_pkg::ID_W-1:0];
        default: begin
          null_id_r <= null_id_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        fill_r <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_id_r    <= out_id_nxt;
      out_index_r <= out_index_nxt;
      out_hit_r   <= out_hit_nxt;
      out_count_r <= rmtf_pkg::CNT_OUT_W'(fill_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_id_out      = out_id_r;
  assign out_index_out   = out_index_r;
  assign out_hit         = out_hit_r;
  assign out_entry_count = out_count_r;

  `RMTF_ASSERT_NEXT(a_strobe_follows_accept, accept, out_valid)
  `RMTF_ASSERT_ALWAYS(a_fill_in_range, fill_r <= rmtf_pkg::CNT_W'(D))
  `RMTF_ASSERT_NEXT(a_fill_holds_when_idle, !accept, $stable(fill_r))
  `RMTF_ASSERT_NEXT(a_count_reports_fill, accept,
                    out_entry_count == rmtf_pkg::CNT_OUT_W'(fill_r))

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;

  typedef struct packed {
    logic [rmtf_pkg::ID_W-1:0]      id_out;
    logic [rmtf_pkg::IDX_OUT_W-1:0] index_out;
    logic                           hit;
    logic [rmtf_pkg::CNT_OUT_W-1:0] count;
  } lookup_result_t;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  logic [rmtf_pkg::REQ_W-1:0]     in_req_type;
  logic [rmtf_pkg::ID_W-1:0]      in_task_id;
  logic [rmtf_pkg::POS_W-1:0]     in_position;
  logic                           out_valid;
  logic [rmtf_pkg::ID_W-1:0]      out_id_out;
  logic [rmtf_pkg::IDX_OUT_W-1:0] out_index_out;
  logic                           out_hit;
  logic [rmtf_pkg::CNT_OUT_W-1:0] out_entry_count;
  logic                           cfg_we;
  logic [rmtf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rmtf_pkg::MASK_W-1:0]    cfg_wdata;

  // shadow copy of the list and its registers
  logic [rmtf_pkg::ID_W-1:0]   list_entries [rmtf_pkg::LIST_DEPTH];
  int                          list_fill;
  logic [rmtf_pkg::MASK_W-1:0] allowed_bits [4];
  logic [rmtf_pkg::ID_W-1:0]   null_code;

  lookup_result_t            pending_results[$];
  int                        mismatches;
  int                        sender_idle_pct;
  logic [rmtf_pkg::ID_W-1:0] id_pool_base;

  recent_id_list_move_to_front dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_task_id      (in_task_id),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_id_out      (out_id_out),
    .out_index_out   (out_index_out),
    .out_hit         (out_hit),
    .out_entry_count (out_entry_count),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic void insert_front(int top, logic [rmtf_pkg::ID_W-1:0] id);
    for (int k = top; k > 0; k--) list_entries[k] = list_entries[k-1];
    list_entries[0] = id;
  endfunction

  function automatic lookup_result_t predict_request(rmtf_pkg::req_t req,
                                                     logic [rmtf_pkg::ID_W-1:0] id,
                                                     logic [rmtf_pkg::POS_W-1:0] pos);
    lookup_result_t res;
    int slot;
    bit found;
    res = '0;
    slot = 0;
    found = 1'b0;
    case (req)
      rmtf_pkg::REQ_ADD: begin
        for (int i = 0; i < list_fill; i++) begin
          if (!found && list_entries[i] == id) begin
            slot = i;
            found = 1'b1;
          end
        end
        if (found) begin
          insert_front(slot, id);
        end else if (allowed_bits[id[7:6]][id[5:0]] && id != null_code) begin
          insert_front((list_fill < rmtf_pkg::LIST_DEPTH) ? list_fill
                                                          : rmtf_pkg::LIST_DEPTH - 1, id);
          if (list_fill < rmtf_pkg::LIST_DEPTH) list_fill++;
        end
      end
      rmtf_pkg::REQ_DEL: begin
        if (pos < list_fill) begin
          list_fill--;
          for (int i = pos; i < list_fill; i++) list_entries[i] = list_entries[i+1];
        end
      end
      rmtf_pkg::REQ_GET: begin
        if (pos < list_fill) begin
          res.id_out = list_entries[pos];
          res.hit = 1'b1;
        end else begin
          res.id_out = null_code;
        end
      end
      default: begin
        for (int i = 0; i < list_fill; i++) begin
          if (!found && list_entries[i] == id) begin
            res.index_out = i[rmtf_pkg::IDX_OUT_W-1:0];
            res.hit = 1'b1;
            found = 1'b1;
          end
        end
      end
    endcase
    res.count = list_fill[rmtf_pkg::CNT_OUT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    lookup_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no transaction pending");
      end else begin
        want = pending_results.pop_front();
        if (out_id_out !== want.id_out)
          report_mismatch($sformatf("id_out %0h expected %0h", out_id_out, want.id_out));
        if (out_index_out !== want.index_out)
          report_mismatch($sformatf("index_out %0d expected %0d", out_index_out,
                                    want.index_out));
        if (out_hit !== want.hit)
          report_mismatch($sformatf("hit %0b expected %0b", out_hit, want.hit));
        if (out_entry_count !== want.count)
          report_mismatch($sformatf("entry_count %0d expected %0d", out_entry_count,
                                    want.count));
      end
    end
  end

  // one transaction, with an optional idle gap in front of it
  task automatic send_item(rmtf_pkg::req_t req, logic [rmtf_pkg::ID_W-1:0] id,
                           logic [rmtf_pkg::POS_W-1:0] pos);
    // each cycle idles with the given percentage
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      @(negedge clk);
      start       <= 1'b0;
      in_req_type <= rmtf_pkg::REQ_W'($urandom_range(0, 3));
      in_task_id  <= rmtf_pkg::ID_W'($urandom_range(0, 255));
      in_position <= rmtf_pkg::POS_W'($urandom_range(0, 255));
    end
    @(negedge clk);
    start       <= 1'b1;
    in_req_type <= req;
    in_task_id  <= id;
    in_position <= pos;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(predict_request(req, id, pos));
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_register(logic [rmtf_pkg::CFG_IDX_W-1:0] idx,
                                logic [rmtf_pkg::MASK_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      rmtf_pkg::CFG_MASK_0:  allowed_bits[0] = data;
      rmtf_pkg::CFG_MASK_1:  allowed_bits[1] = data;
      rmtf_pkg::CFG_MASK_2:  allowed_bits[2] = data;
      rmtf_pkg::CFG_MASK_3:  allowed_bits[3] = data;
      rmtf_pkg::CFG_NULL_ID: null_code = data[rmtf_pkg::ID_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_config(logic [rmtf_pkg::MASK_W-1:0] m0, logic [rmtf_pkg::MASK_W-1:0] m1,
                             logic [rmtf_pkg::MASK_W-1:0] m2, logic [rmtf_pkg::MASK_W-1:0] m3,
                             logic [rmtf_pkg::ID_W-1:0] nul);
    write_register(rmtf_pkg::CFG_MASK_0, m0);
    write_register(rmtf_pkg::CFG_MASK_1, m1);
    write_register(rmtf_pkg::CFG_MASK_2, m2);
    write_register(rmtf_pkg::CFG_MASK_3, m3);
    write_register(rmtf_pkg::CFG_NULL_ID, {{(rmtf_pkg::MASK_W-rmtf_pkg::ID_W){1'b0}}, nul});
  endtask

  // mostly ids from a small pool so that adds repeat and finds hit
  function automatic logic [rmtf_pkg::ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return id_pool_base + rmtf_pkg::ID_W'($urandom_range(0, 11));
    if (r < 80 && list_fill > 0) return list_entries[$urandom_range(0, list_fill - 1)];
    return rmtf_pkg::ID_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [rmtf_pkg::POS_W-1:0] pick_position();
    if ($urandom_range(0, 99) < 85)
      return rmtf_pkg::POS_W'($urandom_range(0, rmtf_pkg::LIST_DEPTH + 1));
    return rmtf_pkg::POS_W'($urandom_range(0, 255));
  endfunction

  task automatic run_random(int count);
    int r;
    rmtf_pkg::req_t req;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 40) req = rmtf_pkg::REQ_ADD;
      else if (r < 55) req = rmtf_pkg::REQ_DEL;
      else if (r < 75) req = rmtf_pkg::REQ_GET;
      else req = rmtf_pkg::REQ_FIND;
      send_item(req, pick_id(), pick_position());
    end
  endtask

  task automatic test_list_basics();
    sender_idle_pct = 27;
    load_config('1, '0, {32{2'b10}}, '1, 8'd0);
    // empty list
    send_item(rmtf_pkg::REQ_GET, 8'd0, 8'd0);
    send_item(rmtf_pkg::REQ_GET, 8'd0, 8'd255);
    send_item(rmtf_pkg::REQ_DEL, 8'd0, 8'd0);
    send_item(rmtf_pkg::REQ_FIND, 8'd7, 8'd0);
    // null id and ids outside the mask are refused, allowed ids are added
    send_item(rmtf_pkg::REQ_ADD, 8'd0, 8'd0);
    send_item(rmtf_pkg::REQ_ADD, 8'd64, 8'd0);
    send_item(rmtf_pkg::REQ_ADD, 8'd128, 8'd0);
    send_item(rmtf_pkg::REQ_ADD, 8'd129, 8'd255);
    send_item(rmtf_pkg::REQ_ADD, 8'd255, 8'd0);
    for (int i = 1; i <= 6; i++) send_item(rmtf_pkg::REQ_ADD, i[rmtf_pkg::ID_W-1:0], 8'd0);
    // full list drops its oldest entry
    send_item(rmtf_pkg::REQ_ADD, 8'd7, 8'd0);
    send_item(rmtf_pkg::REQ_ADD, 8'd3, 8'd0);
    send_item(rmtf_pkg::REQ_FIND, 8'd129, 8'd0);
    send_item(rmtf_pkg::REQ_FIND, 8'd255, 8'd0);
    send_item(rmtf_pkg::REQ_GET, 8'd0, 8'd7);
    send_item(rmtf_pkg::REQ_GET, 8'd0, 8'd8);
    send_item(rmtf_pkg::REQ_DEL, 8'd0, 8'd200);
    send_item(rmtf_pkg::REQ_DEL, 8'd0, 8'd7);
    send_item(rmtf_pkg::REQ_DEL, 8'd0, 8'd0);
    wait_for_results();
  endtask

  // listed ids still move to front once refused by mask or null id
  task automatic test_listed_ids_move();
    load_config('0, '1, '1, '0, 8'd5);
    send_item(rmtf_pkg::REQ_ADD, 8'd5, 8'd0);
    send_item(rmtf_pkg::REQ_ADD, 8'd6, 8'd0);
    send_item(rmtf_pkg::REQ_ADD, 8'd9, 8'd0);
    send_item(rmtf_pkg::REQ_GET, 8'd0, 8'd0);
    wait_for_results();
  endtask

  task automatic test_open_masks();
    id_pool_base = rmtf_pkg::ID_W'($urandom_range(0, 244));
    load_config('1, '1, '1, '1, id_pool_base + 8'd3);
    run_random(170);
    wait_for_results();
  endtask

  task automatic test_closed_masks();
    load_config('0, '0, '0, '0, 8'd255);
    run_random(40);
    wait_for_results();
  endtask

  task automatic test_random_masks();
    sender_idle_pct = 83;
    id_pool_base = rmtf_pkg::ID_W'($urandom_range(0, 244));
    load_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, rmtf_pkg::ID_W'($urandom_range(0, 255)));
    run_random(170);
    wait_for_results();
  endtask

  task automatic test_full_speed();
    sender_idle_pct = 0;
    id_pool_base = 8'd244;
    load_config('1, '1, '1, '1, 8'd255);
    run_random(150);
    wait_for_results();
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_req_type     = rmtf_pkg::REQ_ADD;
    in_task_id      = '0;
    in_position     = '0;
    cfg_we          = 1'b0;
    cfg_index       = rmtf_pkg::CFG_MASK_0;
    cfg_wdata       = '0;
    mismatches      = 0;
    sender_idle_pct = 0;
    id_pool_base    = '0;
    list_fill       = 0;
    null_code       = '0;
    for (int i = 0; i < 4; i++) allowed_bits[i] = '0;
    for (int i = 0; i < rmtf_pkg::LIST_DEPTH; i++) list_entries[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_list_basics();
    test_listed_ids_move();
    test_open_masks();
    test_closed_masks();
    test_random_masks();
    test_full_speed();

    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
